// ----- sv/dtt_pkg.sv -----
// dtt_pkg: shared types and constants for the deadline timer table.
// Used by dtt_store, dtt_scan and deadline_timer_table; depends on nothing.
package dtt_pkg;

  // Table size and derived widths
  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TIME_W = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;

  // Command codes
  localparam logic [1:0] FUNC_ARM    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_OK  = 2'd0;
  localparam logic [1:0] KIND_ERR = 2'd1;
  localparam logic [1:0] KIND_EXP = 2'd2;

  // Midpoint of the order key: offset zero maps here
  localparam time_t KEY_MID = time_t'(1) << (TIME_W - 1);

  // Input word
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  conn_id;
    logic [19:0] timeout;
    logic [31:0] now;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       last;
  } result_t;

  // Requests from the sequencer to the slot store
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_idx;
    time_t wr_data;
    logic  clr_en;
    idx_t  clr_idx;
    logic  rd_en;
    idx_t  rd_idx;
  } store_req_t;

endpackage

// ----- sv/dtt_store.sv -----
// dtt_store: deadline memory (one read port, registered) plus armed flags.
// Depends on dtt_pkg.
module dtt_store (
  input  logic                    clk,
  input  logic                    rst,
  input  dtt_pkg::store_req_t     req,
  output logic [dtt_pkg::SLOTS-1:0] armed,
  output logic                    rd_armed,
  output dtt_pkg::time_t          rd_deadline
);

  dtt_pkg::time_t mem [dtt_pkg::SLOTS];

  // Deadline memory: written on arm, read during a scan
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_deadline <= mem[req.rd_idx];
    end
  end

  // Armed flags, cleared at reset; arm and clear never hit in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= '0;
      rd_armed <= 1'b0;
    end else begin
      if (req.wr_en) begin
        armed[req.wr_idx] <= 1'b1;
      end
      if (req.clr_en) begin
        armed[req.clr_idx] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_armed <= armed[req.rd_idx];
      end
    end
  end

  // An arm leaves its slot armed
  a_arm_sets: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(req.wr_en) |-> armed[$past(req.wr_idx)])
    else $error("armed flag not set after arm");

endmodule

// ----- sv/dtt_scan.sv -----
// dtt_scan: shared compare unit; one slot per cycle while vld is high, keeps earliest
// due slot and a count of due slots for the current pass. Depends on dtt_pkg.
module dtt_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             vld,
  input  dtt_pkg::idx_t    idx,
  input  logic             armed,
  input  dtt_pkg::time_t   deadline,
  input  dtt_pkg::time_t   now,
  output logic             found,
  output dtt_pkg::idx_t    best_idx,
  output dtt_pkg::cnt_t    due_cnt
);

  dtt_pkg::time_t best_key;
  dtt_pkg::time_t key;
  logic           due;
  logic           better;

  // Signed offset mapped to an unsigned key; due when offset <= 0
  always_comb begin
    key    = (deadline - now) ^ dtt_pkg::KEY_MID;
    due    = armed && (key <= dtt_pkg::KEY_MID);
    better = due && (!found || (key < best_key));
  end

  // Running minimum; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      found   <= 1'b0;
      due_cnt <= '0;
    end else if (vld) begin
      if (due) begin
        due_cnt <= due_cnt + dtt_pkg::cnt_t'(1);
      end
      if (better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld && better) begin
      best_key <= key;
      best_idx <= idx;
    end
  end

  // A found slot means at least one due slot was counted
  a_found_cnt: assert property (@(posedge clk) disable iff (rst)
    found |-> due_cnt != '0)
    else $error("found without due count");

endmodule

// ----- sv/deadline_timer_table.sv -----
// deadline_timer_table: top level; command decode and scan sequencer.
// Depends on dtt_pkg, dtt_store and dtt_scan.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-------------------------------
//   command  | start, busy, cmd         | word taken when start && !busy
//   result   | result_stb, result       | word valid for one cycle only
//
// Arm and cancel leave busy low; the result appears the next cycle. A tick
// runs one pass over all slots per expiry (one memory read per cycle through
// the single compare unit), and at least one pass: max(1, due slots) passes.
// Reset is synchronous: all timers disarmed, no pass in flight.
// The receiver cannot stall; each result word is shown for one cycle.
module deadline_timer_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dtt_pkg::cmd_t      cmd,
  output logic               result_stb,
  output dtt_pkg::result_t   result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  localparam dtt_pkg::idx_t IdxMax = dtt_pkg::idx_t'(dtt_pkg::SLOTS - 1);

  state_t                     st;
  dtt_pkg::idx_t              rd_idx;
  dtt_pkg::idx_t              rd_idx_q;
  logic                       rd_vld;
  dtt_pkg::time_t             cur_now;

  dtt_pkg::store_req_t        req;
  logic [dtt_pkg::SLOTS-1:0]  armed;
  logic                       rd_armed;
  dtt_pkg::time_t             rd_deadline;
  logic                       found;
  dtt_pkg::idx_t              best_idx;
  dtt_pkg::cnt_t              due_cnt;

  logic                       accept;
  logic                       in_range;
  dtt_pkg::idx_t              id_ix;
  logic                       scan_clr;

  assign busy = (st != ST_IDLE);

  // Command decode and store requests
  always_comb begin
    accept   = start && (st == ST_IDLE);
    in_range = 32'(cmd.conn_id) < 32'(dtt_pkg::SLOTS);
    id_ix    = dtt_pkg::idx_t'(cmd.conn_id);
    scan_clr = accept || (st == ST_DONE);

    req         = '0;
    req.wr_idx  = id_ix;
    req.wr_data = cmd.now + dtt_pkg::time_t'(cmd.timeout);
    req.wr_en   = accept && in_range && (cmd.func == dtt_pkg::FUNC_ARM);
    req.rd_en   = (st == ST_SCAN);
    req.rd_idx  = rd_idx;
    if (st == ST_DONE) begin
      req.clr_en  = found;
      req.clr_idx = best_idx;
    end else begin
      req.clr_en  = accept && in_range && (cmd.func == dtt_pkg::FUNC_CANCEL)
                    && armed[id_ix];
      req.clr_idx = id_ix;
    end
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      rd_idx     <= '0;
      rd_vld     <= 1'b0;
      result_stb <= 1'b0;
    end else begin
      result_stb <= 1'b0;
      rd_vld     <= (st == ST_SCAN);
      rd_idx_q   <= rd_idx;
      unique case (st)
        ST_IDLE: begin
          if (start) begin
            result.slot <= cmd.conn_id;
            result.last <= 1'b1;
            case (cmd.func)
              dtt_pkg::FUNC_ARM: begin
                result_stb  <= 1'b1;
                result.kind <= in_range ? dtt_pkg::KIND_OK : dtt_pkg::KIND_ERR;
              end
              dtt_pkg::FUNC_CANCEL: begin
                result_stb  <= 1'b1;
                result.kind <= (in_range && armed[id_ix]) ? dtt_pkg::KIND_OK
                                                          : dtt_pkg::KIND_ERR;
              end
              dtt_pkg::FUNC_TICK: begin
                st      <= ST_SCAN;
                rd_idx  <= '0;
                cur_now <= cmd.now;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_idx == IdxMax) begin
            st <= ST_DRAIN;
          end else begin
            rd_idx <= rd_idx + dtt_pkg::idx_t'(1);
          end
        end
        ST_DRAIN: begin
          st <= ST_DONE;
        end
        ST_DONE: begin
          if (found) begin
            result_stb  <= 1'b1;
            result.kind <= dtt_pkg::KIND_EXP;
            result.slot <= 4'(best_idx);
            result.last <= (due_cnt == dtt_pkg::cnt_t'(1));
            if (due_cnt == dtt_pkg::cnt_t'(1)) begin
              st <= ST_IDLE;
            end else begin
              st     <= ST_SCAN;
              rd_idx <= '0;
            end
          end else begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  dtt_store u_store (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .armed       (armed),
    .rd_armed    (rd_armed),
    .rd_deadline (rd_deadline)
  );

  dtt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .clr      (scan_clr),
    .vld      (rd_vld),
    .idx      (rd_idx_q),
    .armed    (rd_armed),
    .deadline (rd_deadline),
    .now      (cur_now),
    .found    (found),
    .best_idx (best_idx),
    .due_cnt  (due_cnt)
  );

  // More expiries to come means the sequencer is still running
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_stb && !result.last |-> busy)
    else $error("non-final result while idle");

  // A result word follows an accepted command or the end of a pass
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && result_stb |-> $past(accept) || $past(st == ST_DONE))
    else $error("result word without a source");

endmodule

// ----- test/deadline_timer_table_test.sv -----
`timescale 1ns / 100ps
// deadline_timer_table_test: self-checking testbench for the deadline timer table.
// Depends on dtt_pkg and deadline_timer_table; uses a scoreboard that predicts every result word.
module deadline_timer_table_test;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_TAIL   = 50;
  localparam int SETTLE       = 4 * (dtt_pkg::SLOTS + 2);
  localparam int CYCLE_LIMIT  = 600_000;

  // Predicts the timer table and checks result words against it
  class timer_scoreboard;
    bit               armed[dtt_pkg::SLOTS];
    dtt_pkg::time_t   deadline[dtt_pkg::SLOTS];
    dtt_pkg::result_t awaited[$];
    int               errors;

    function new();
      for (int i = 0; i < dtt_pkg::SLOTS; i++) begin
        armed[i]    = 1'b0;
        deadline[i] = '0;
      end
      errors = 0;
    endfunction

    // Apply one accepted command word and queue the words it should cause
    function void note_command(dtt_pkg::cmd_t c);
      dtt_pkg::result_t    r;
      dtt_pkg::result_t    held;
      bit                  have;
      int                  best;
      int                  i;
      logic signed [31:0]  offset;
      logic signed [31:0]  best_off;
      r.last = 1'b1;
      r.slot = c.conn_id;
      case (c.func) inside
        dtt_pkg::FUNC_ARM, dtt_pkg::FUNC_CANCEL: begin
          if (int'(c.conn_id) >= dtt_pkg::SLOTS) begin
            r.kind = dtt_pkg::KIND_ERR;
          end else if (c.func == dtt_pkg::FUNC_ARM) begin
            deadline[c.conn_id] = c.now + dtt_pkg::time_t'(c.timeout);
            armed[c.conn_id]    = 1'b1;
            r.kind              = dtt_pkg::KIND_OK;
          end else if (armed[c.conn_id]) begin
            armed[c.conn_id]    = 1'b0;
            deadline[c.conn_id] = '0;
            r.kind              = dtt_pkg::KIND_OK;
          end else begin
            r.kind = dtt_pkg::KIND_ERR;
          end
          awaited.push_back(r);
        end
        dtt_pkg::FUNC_TICK: begin
          // expire due slots earliest first; the previous word is held back
          // so the final one can carry the last flag
          have = 1'b0;
          do begin
            best     = -1;
            best_off = '0;
            for (i = 0; i < dtt_pkg::SLOTS; i++) begin
              if (armed[i]) begin
                offset = deadline[i] - c.now;
                if (offset <= 0 && (best < 0 || offset < best_off)) begin
                  best     = i;
                  best_off = offset;
                end
              end
            end
            if (best >= 0) begin
              armed[best]    = 1'b0;
              deadline[best] = '0;
              if (have) awaited.push_back(held);
              held.kind = dtt_pkg::KIND_EXP;
              held.slot = 4'(best);
              held.last = 1'b0;
              have      = 1'b1;
            end
          end while (best >= 0);
          if (have) begin
            held.last = 1'b1;
            awaited.push_back(held);
          end
        end
        default: ; // unused code: ignored
      endcase
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(dtt_pkg::result_t got);
      dtt_pkg::result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result word: kind %0d slot %0d last %0d",
               got.kind, got.slot, got.last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  dtt_pkg::cmd_t    cmd_word;
  logic             result_stb;
  dtt_pkg::result_t result_word;
  bit               quiet_tail;
  int               cycle_count;

  timer_scoreboard book = new();

  deadline_timer_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd_word),
    .result_stb (result_stb),
    .result     (result_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Monitor: check result words first, then note the word taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_stb === 1'b1) book.check_result(result_word);
      if (start === 1'b1 && busy === 1'b0) book.note_command(cmd_word);
    end
  end

  function automatic dtt_pkg::cmd_t make_cmd(logic [1:0] func, logic [3:0] id,
                                             logic [19:0] tmo, dtt_pkg::time_t now);
    dtt_pkg::cmd_t c;
    c.func    = func;
    c.conn_id = id;
    c.timeout = tmo;
    c.now     = now;
    return c;
  endfunction

  // Present one word, with an occasional idle burst before it, and hold it
  // until it is taken
  task automatic send_word(dtt_pkg::cmd_t c);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        start    = 1'b0;
        cmd_word = make_cmd(2'($urandom), 4'($urandom), 20'($urandom), $urandom);
      end
    end
    @(negedge clk);
    start    = 1'b1;
    cmd_word = c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(make_cmd(dtt_pkg::FUNC_CANCEL, 4'd0, 20'd0, 32'd0)); // cancel of an idle slot
    send_word(make_cmd(dtt_pkg::FUNC_TICK, 4'd0, 20'd0, 32'd0));   // nothing due
    send_word(make_cmd(FUNC_UNUSED, 4'hF, 20'hFFFFF, 32'hFFFF_FFFF));
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd0, 20'd0, 32'd100));  // due at once
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd7, 20'd5, 32'd100));
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd2, 20'd3, 32'd100));
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd7, 20'd1, 32'd100));  // re-arm replaces
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd4, 20'd1, 32'd100));  // ties with slot 7
    send_word(make_cmd(dtt_pkg::FUNC_CANCEL, 4'd2, 20'd0, 32'd100));
    send_word(make_cmd(dtt_pkg::FUNC_CANCEL, 4'd2, 20'd0, 32'd100)); // already cancelled
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd15, 20'hFFFFF, 32'hFFFF_FFF0)); // wraps past zero
    send_word(make_cmd(dtt_pkg::FUNC_TICK, 4'd0, 20'd0, 32'd101));
    // half-range offsets: exactly 2^31 behind is due, 2^31 - 1 ahead is not
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd5, 20'd0, 32'd0));
    send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'd6, 20'd0, 32'hFFFF_FFFF));
    send_word(make_cmd(dtt_pkg::FUNC_TICK, 4'hF, 20'hFFFFF, 32'h8000_0000));
    send_word(make_cmd(dtt_pkg::FUNC_CANCEL, 4'd6, 20'd0, 32'd0));
    send_word(make_cmd(dtt_pkg::FUNC_CANCEL, 4'd15, 20'd0, 32'd0));
  endtask

  // Mostly arms and ticks on a moving clock so timers really expire;
  // some full-table rounds, odd timestamps and unused codes as noise
  task automatic run_random();
    dtt_pkg::cmd_t  c;
    dtt_pkg::time_t clock_now;
    int             sent;
    int             pick;
    int             sel;
    int             i;
    clock_now = $urandom;
    sent      = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet_tail = (sent >= RANDOM_ITEMS - QUIET_TAIL);
      c    = make_cmd(dtt_pkg::FUNC_ARM, 4'($urandom), 20'($urandom), clock_now);
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      if (pick < 45) begin
        if (sel == 0) c.timeout = '0;
        else if (sel == 1) c.timeout = '1;
        else if (sel < 4) c.timeout = 20'($urandom);
        else c.timeout = 20'($urandom_range(0, 40));
        if (sel == 19) c.now = $urandom;
        send_word(c);
        sent++;
      end else if (pick < 60) begin
        c.func = dtt_pkg::FUNC_CANCEL;
        send_word(c);
        sent++;
      end else if (pick < 90) begin
        if (sel == 0) clock_now += 32'h8000_0000;
        else if (sel == 1) clock_now += $urandom;
        else if (sel < 4) clock_now += 32'($urandom_range(0, 20'hFFFFF));
        else clock_now += 32'($urandom_range(0, 25));
        c.func = dtt_pkg::FUNC_TICK;
        c.now  = clock_now;
        send_word(c);
        sent++;
      end else if (pick < 94) begin
        // fill the table, then expire the lot in one tick
        for (i = 0; i < dtt_pkg::SLOTS; i++) begin
          send_word(make_cmd(dtt_pkg::FUNC_ARM, 4'(i), 20'($urandom_range(0, 50)),
                             clock_now));
        end
        clock_now += 32'd60;
        send_word(make_cmd(dtt_pkg::FUNC_TICK, 4'($urandom), 20'($urandom), clock_now));
        sent += dtt_pkg::SLOTS + 1;
      end else begin
        c.func = FUNC_UNUSED;
        c.now  = $urandom;
        send_word(c);
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd_word   = '0;
    quiet_tail = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_random();

    // drain: wait for every awaited word, then allow for a trailing scan
    @(negedge clk);
    start = 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (book.errors == 0 && book.awaited.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- deadline_timer_table.f -----
sv/dtt_pkg.sv
sv/dtt_store.sv
sv/dtt_scan.sv
sv/deadline_timer_table.sv
test/deadline_timer_table_test.sv
